FILE: hdl/rect_blit_address_generator_macros.svh
// Assertion macros for the rectangle blit address generator checker.
// Needs signals clk and arst_n in the scope of use.
`ifndef RECT_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define RECT_BLIT_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication
`define RBAG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RBAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rbag_pkg.sv
// Shared constants and types for the rectangle blit address generator.
// No dependencies.
package rbag_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int CNT_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int POS_W    = 10;
	localparam int SIZE_W   = 11;
	localparam int MODE_W   = 2;
	localparam int PIX_W    = 16;
	localparam int OFFSET_W = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int OUT_FIELDS_W = 1 + OFFSET_W + PIX_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int IN_DATA_W    = ((PIX_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUFFER_SELECT = 3'd0,
		REG_DEST_X        = 3'd1,
		REG_DEST_Y        = 3'd2,
		REG_RECT_W        = 3'd3,
		REG_RECT_H        = 3'd4,
		REG_LINE_PITCH    = 3'd5,
		REG_BLIT_MODE     = 3'd6,
		REG_FILL_COLOR    = 3'd7
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_FILL   = 2'd0,
		MODE_COPY   = 2'd1,
		MODE_ROTATE = 2'd2,
		MODE_SPARE  = 2'd3
	} blit_mode_t;

endpackage

FILE: hdl/rect_blit_address_generator.sv
// Rectangle blit address generator: top level.
// Depends on rbag_pkg.
//
// Turns each pixel item into one framebuffer write. A new item is taken
// every clock while s_tready is high; its write appears on the output in
// the cycle after acceptance. The only rate limit is the single output
// register: s_tready is high whenever that register is empty or being
// drained. Column/row counters walk the rectangle in source raster order and
// wrap after the last pixel; the offset costs one add, a 20x20 multiply, two
// more adds and, in rotate mode, a subtract in that single stage. Configuration
// must be written only while no item is in flight; the block does not enforce it.
module rect_blit_address_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rbag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rbag_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] src_pixel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rbag_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] out_buffer, [20:1] out_offset,
	                                                      // [36:21] out_data, rest zero
	output logic                               m_tlast    // last_write
);
	import rbag_pkg::*;

	logic                buffer_select_q;
	logic [POS_W-1:0]    dest_x_q;
	logic [POS_W-1:0]    dest_y_q;
	logic [SIZE_W-1:0]   rect_w_q;
	logic [SIZE_W-1:0]   rect_h_q;
	logic [SIZE_W-1:0]   line_pitch_q;
	logic [MODE_W-1:0]   blit_mode_q;
	logic [PIX_W-1:0]    fill_color_q;

	logic [CNT_W-1:0]    col_q;
	logic [CNT_W-1:0]    row_q;

	logic                out_valid_q;
	logic                out_buffer_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic [PIX_W-1:0]    out_data_q;
	logic                out_last_q;

	logic                accept;
	logic [CNT_W-1:0]    w_last;
	logic [CNT_W-1:0]    h_last;
	logic [CNT_W-1:0]    row_clamped;
	logic                rotate;
	logic                row_end;
	logic                rect_end;
	logic [OFFSET_W-1:0] line_idx;
	logic [OFFSET_W-1:0] line_base;
	logic [OFFSET_W-1:0] col_idx;
	logic [OFFSET_W-1:0] offset;
	logic [PIX_W-1:0]    data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_select_q <= 1'b0;
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			rect_w_q        <= SIZE_W'(1);
			rect_h_q        <= SIZE_W'(1);
			line_pitch_q    <= SIZE_W'(320);
			blit_mode_q     <= MODE_FILL;
			fill_color_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BUFFER_SELECT: buffer_select_q <= cfg_data[0];
				REG_DEST_X:        dest_x_q        <= cfg_data[POS_W-1:0];
				REG_DEST_Y:        dest_y_q        <= cfg_data[POS_W-1:0];
				REG_RECT_W:        rect_w_q        <= cfg_data[SIZE_W-1:0];
				REG_RECT_H:        rect_h_q        <= cfg_data[SIZE_W-1:0];
				REG_LINE_PITCH:    line_pitch_q    <= cfg_data[SIZE_W-1:0];
				REG_BLIT_MODE:     blit_mode_q     <= cfg_data[MODE_W-1:0];
				REG_FILL_COLOR:    fill_color_q    <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// zero size acts as one, oversize acts as the maximum
	always_comb begin
		if (rect_w_q == '0)
			w_last = '0;
		else if (32'(rect_w_q) > MAX_WIDTH)
			w_last = CNT_W'(MAX_WIDTH - 1);
		else
			w_last = CNT_W'(rect_w_q - SIZE_W'(1));

		if (rect_h_q == '0)
			h_last = '0;
		else if (32'(rect_h_q) > MAX_HEIGHT)
			h_last = CNT_W'(MAX_HEIGHT - 1);
		else
			h_last = CNT_W'(rect_h_q - SIZE_W'(1));
	end

	always_comb begin
		row_clamped = (row_q > h_last) ? h_last : row_q;
		rotate      = (blit_mode_t'(blit_mode_q) == MODE_ROTATE);
		row_end     = (col_q >= w_last);
		rect_end    = row_end && (row_q >= h_last);

		if (rotate) begin
			line_idx = OFFSET_W'(dest_y_q) + OFFSET_W'(col_q);
			col_idx  = OFFSET_W'(h_last - row_clamped);
		end else begin
			line_idx = OFFSET_W'(dest_y_q) + OFFSET_W'(row_clamped);
			col_idx  = OFFSET_W'(col_q);
		end
		line_base = OFFSET_W'(line_idx * OFFSET_W'(line_pitch_q));
		offset    = line_base + OFFSET_W'(dest_x_q) + col_idx;

		if (blit_mode_t'(blit_mode_q) == MODE_FILL)
			data = fill_color_q;
		else
			data = s_tdata[PIX_W-1:0];
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= rect_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_tready)
			out_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_buffer_q <= buffer_select_q;
			out_offset_q <= offset;
			out_data_q   <= data;
			out_last_q   <= rect_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_data_q, out_offset_q, out_buffer_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: hdl/rbag_checker.sv
// Port-level checker for the rectangle blit address generator, with its bind.
// Depends on rbag_pkg and rect_blit_address_generator_macros.svh.
`include "rect_blit_address_generator_macros.svh"

module rbag_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rbag_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import rbag_pkg::*;

	// an empty output register never blocks the input
	`RBAG_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

	// every accepted item shows up on the output next cycle
	`RBAG_ASSERT_NEXT(a_accept_to_out, s_tvalid && s_tready, m_tvalid, "accepted item not presented")

	// no item appears without an accepted input
	`RBAG_ASSERT_NEXT(a_no_invented, !(s_tvalid && s_tready) && !(m_tvalid && !m_tready), !m_tvalid, "output item without input")

	// a stalled write holds its payload
	`RBAG_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

endmodule

bind rect_blit_address_generator rbag_checker u_rbag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
